@@ design/mcec_pkg.sv @@
// Shared constants, opcodes and controller/datapath interface types for the executor.
package mcec_pkg;

	localparam int DataWordsDef = 64;
	localparam int ProgLinesDef = 1024;

	localparam int PcW  = 11;
	localparam int TotW = 24;
	localparam int CntW = 20;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_DIV  = 4'd2;
	localparam logic [3:0] OP_MULT = 4'd3;
	localparam logic [3:0] OP_SLT  = 4'd4;
	localparam logic [3:0] OP_LW   = 4'd5;
	localparam logic [3:0] OP_SW   = 4'd6;
	localparam logic [3:0] OP_BEQ  = 4'd7;
	localparam logic [3:0] OP_ADDI = 4'd8;
	localparam logic [3:0] OP_J    = 4'd9;
	localparam logic [3:0] OP_SHOW = 4'd10;

	localparam logic [2:0] COST_NONE = 3'd0;
	localparam logic [2:0] COST_BR   = 3'd3;
	localparam logic [2:0] COST_ALU  = 3'd4;
	localparam logic [2:0] COST_LW   = 3'd5;

	localparam logic [CntW-1:0] INSTR_LIMIT = 20'd1000000;

	typedef struct packed {
		logic load;
		logic rd_a;
		logic rd_b;
		logic rd_base;
		logic exec;
		logic capture;
		logic commit;
	} mcec_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic skip;
		logic exec_wait;
		logic wait_done;
		logic out_free;
	} mcec_stat_t;

endpackage

@@ design/mcec_div.sv @@
// Iterative signed 32-bit divider producing one quotient bit per cycle.
module mcec_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic        take;

	assign rem_sh  = {rem_q, quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign take    = !rem_sub[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			dvs_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[30:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule

@@ design/mcec_dp.sv @@
// Datapath: register file, data memory with clearing pass, ALU, counters and result register.
module mcec_dp #(
	parameter int DATA_WORDS    = mcec_pkg::DataWordsDef,
	parameter int PROGRAM_LINES = mcec_pkg::ProgLinesDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcec_pkg::mcec_cmd_t         cmd,
	output mcec_pkg::mcec_stat_t        stat,
	input  logic                        cfg_wr,
	input  logic [mcec_pkg::PcW-1:0]    cfg_data,
	input  logic [3:0]                  operation,
	input  logic [3:0]                  first_reg,
	input  logic [3:0]                  second_reg,
	input  logic [3:0]                  base_reg,
	input  logic signed [31:0]          immediate,
	input  logic [9:0]                  target_line,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mcec_pkg::PcW-1:0]    next_pc,
	output logic [mcec_pkg::TotW-1:0]   multi_cycles,
	output logic [mcec_pkg::CntW-1:0]   instruction_count,
	output logic                        halted,
	output logic                        divide_fault,
	output logic                        address_fault
);
	import mcec_pkg::*;

	localparam int AW       = $clog2(DATA_WORDS);
	localparam int LinesCap = (PROGRAM_LINES > 2047) ? 2047 : PROGRAM_LINES;

	logic [PcW-1:0]  pl_q;
	logic [PcW-1:0]  pc_q;
	logic [TotW-1:0] tot_q;
	logic [CntW-1:0] cnt_q;
	logic            stopped_q;
	logic [PcW-1:0]  limit;

	logic [3:0]  op_q, r1_q, r2_q, rb_q;
	logic [31:0] imm_q;
	logic [9:0]  tgt_q;
	logic        skip_q;
	logic [31:0] a_q, b_q, base_q;

	logic [31:0] rf_q [16];
	logic [3:0]  rd_addr;
	logic [31:0] rd_data;

	logic [31:0] dmem [DATA_WORDS];
	logic [31:0] mem_rdata_q;
	logic        clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic [31:0] addr;
	logic        addr_ok;
	logic        mem_we;

	logic [31:0] res_q;
	logic        wen_q, dfault_q, afault_q, end_q;
	logic [PcW-1:0] npc_q;
	logic [2:0]  cost_q;

	logic        div_go, div_busy, div_done;
	logic [31:0] div_quo;

	logic [TotW:0]   tot_sum;
	logic [TotW-1:0] tot_new;
	logic [CntW-1:0] cnt_new;
	logic            stop_new;
	logic            out_valid_q;

	assign limit = (32'(pl_q) < 32'(LinesCap)) ? pl_q : PcW'(LinesCap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q <= '0;
		end else if (cfg_wr) begin
			pl_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			r1_q   <= first_reg;
			r2_q   <= second_reg;
			rb_q   <= base_reg;
			imm_q  <= immediate;
			tgt_q  <= target_line;
			skip_q <= stat.skip;
		end
	end

	assign rd_addr = cmd.rd_a ? r1_q : (cmd.rd_b ? r2_q : rb_q);
	assign rd_data = rf_q[rd_addr];

	always_ff @(posedge clk) begin
		if (cmd.rd_a) begin
			a_q <= rd_data;
		end
		if (cmd.rd_b) begin
			b_q <= rd_data;
		end
		if (cmd.rd_base) begin
			base_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				rf_q[i] <= '0;
			end
		end else if (cmd.commit && !skip_q && wen_q) begin
			rf_q[r1_q] <= res_q;
		end
	end

	assign addr    = imm_q + base_q;
	assign addr_ok = !addr[31] && (addr < 32'(DATA_WORDS));
	assign mem_we  = cmd.exec && (op_q == OP_SW) && addr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == AW'(DATA_WORDS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			dmem[clr_cnt_q] <= '0;
		end else if (mem_we) begin
			dmem[addr[AW-1:0]] <= a_q;
		end
		mem_rdata_q <= dmem[addr[AW-1:0]];
	end

	assign div_go = cmd.exec && (op_q == OP_DIV) && (b_q != '0);

	mcec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (a_q),
		.divisor  (b_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q    <= '0;
			wen_q    <= 1'b0;
			dfault_q <= 1'b0;
			afault_q <= 1'b0;
			end_q    <= 1'b0;
			npc_q    <= pc_q + 1'b1;
			cost_q   <= COST_ALU;
			case (op_q)
				OP_ADD: begin
					res_q <= a_q + b_q;
					wen_q <= 1'b1;
				end
				OP_SUB: begin
					res_q <= a_q - b_q;
					wen_q <= 1'b1;
				end
				OP_DIV: begin
					wen_q    <= 1'b1;
					dfault_q <= (b_q == '0);
				end
				OP_MULT: begin
					res_q <= a_q * b_q;
					wen_q <= 1'b1;
				end
				OP_SLT: begin
					res_q <= {31'd0, $signed(a_q) < $signed(b_q)};
					wen_q <= 1'b1;
				end
				OP_LW: begin
					wen_q    <= addr_ok;
					afault_q <= !addr_ok;
					cost_q   <= COST_LW;
				end
				OP_SW: begin
					afault_q <= !addr_ok;
				end
				OP_BEQ: begin
					if (a_q == b_q) begin
						npc_q <= PcW'(tgt_q);
					end
					cost_q <= COST_BR;
				end
				OP_ADDI: begin
					res_q <= b_q + imm_q;
					wen_q <= 1'b1;
				end
				OP_J: begin
					npc_q  <= PcW'(tgt_q);
					cost_q <= COST_BR;
				end
				OP_SHOW: begin
					cost_q <= COST_BR;
				end
				default: begin
					npc_q  <= limit;
					end_q  <= 1'b1;
					cost_q <= COST_NONE;
				end
			endcase
			if (r1_q == 4'd0) begin
				wen_q <= 1'b0;
			end
		end else if (cmd.capture) begin
			res_q <= (op_q == OP_LW) ? mem_rdata_q : div_quo;
		end
	end

	assign tot_sum  = {1'b0, tot_q} + (TotW + 1)'(cost_q);
	assign tot_new  = tot_sum[TotW] ? '1 : tot_sum[TotW-1:0];
	assign cnt_new  = cnt_q + 1'b1;
	assign stop_new = end_q || (cnt_new > INSTR_LIMIT) || (npc_q >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			tot_q       <= '0;
			cnt_q       <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (skip_q) begin
					stopped_q <= 1'b1;
				end else begin
					pc_q      <= npc_q;
					tot_q     <= tot_new;
					cnt_q     <= cnt_new;
					stopped_q <= stop_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (skip_q) begin
				next_pc           <= pc_q;
				multi_cycles      <= tot_q;
				instruction_count <= cnt_q;
				halted            <= 1'b1;
				divide_fault      <= 1'b0;
				address_fault     <= 1'b0;
			end else begin
				next_pc           <= npc_q;
				multi_cycles      <= tot_new;
				instruction_count <= cnt_new;
				halted            <= stop_new;
				divide_fault      <= dfault_q;
				address_fault     <= afault_q;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign stat.clear_done = !clr_q;
	assign stat.skip       = stopped_q || (pc_q >= limit);
	assign stat.exec_wait  = ((op_q == OP_DIV) && (b_q != '0)) || ((op_q == OP_LW) && addr_ok);
	assign stat.wait_done  = (op_q == OP_LW) || div_done;
	assign stat.out_free   = !out_valid_q || !out_stall;

	a_reg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rf_q[0] == '0)
		else $error("register zero was written");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free)
		else $error("result overwritten while still held");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !div_busy)
		else $error("divider started while busy");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed item not presented");
endmodule

@@ design/mcec_ctrl.sv @@
// Controller state machine sequencing register reads, execute, wait and commit.
module mcec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mcec_pkg::mcec_stat_t stat,
	output mcec_pkg::mcec_cmd_t  cmd
);
	import mcec_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_RD_A   = 3'd2;
	localparam logic [2:0] S_RD_B   = 3'd3;
	localparam logic [2:0] S_RD_C   = 3'd4;
	localparam logic [2:0] S_EXEC   = 3'd5;
	localparam logic [2:0] S_WAIT   = 3'd6;
	localparam logic [2:0] S_COMMIT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.load    = accept;
		cmd.rd_a    = (state_q == S_RD_A);
		cmd.rd_b    = (state_q == S_RD_B);
		cmd.rd_base = (state_q == S_RD_C);
		cmd.exec    = (state_q == S_EXEC);
		case (state_q)
			S_CLEAR: begin
				if (stat.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = stat.skip ? S_COMMIT : S_RD_A;
				end
			end
			S_RD_A: state_d = S_RD_B;
			S_RD_B: state_d = S_RD_C;
			S_RD_C: state_d = S_EXEC;
			S_EXEC: state_d = stat.exec_wait ? S_WAIT : S_COMMIT;
			S_WAIT: begin
				if (stat.wait_done) begin
					cmd.capture = 1'b1;
					state_d     = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ design/mini_cpu_execute_cycle_counter.sv @@
// Top level of the instruction executor with multi-cycle and instruction counters.
// Each accepted item is one decoded instruction and yields exactly one result item. An item
// holds the input while it reads its three operands, executes, waits for a load with a valid
// address or a divide with a nonzero divisor, and commits; once the block has halted an item
// goes straight to commit. Its result is presented in the same cycle in which the block can
// take the next item. The register file's single read port and the one-bit-per-cycle divider
// set the pace of an item, and a result still held by the receiver adds its wait to the next
// item. A new item is taken while the previous result still waits in the output register.
// After reset the data memory is cleared one word per cycle, and no item is accepted until
// it is done; program_length may be written at any time the block is idle.
module mini_cpu_execute_cycle_counter #(
	parameter int DATA_WORDS    = mcec_pkg::DataWordsDef,
	parameter int PROGRAM_LINES = mcec_pkg::ProgLinesDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mcec_pkg::PcW-1:0]    program_length,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0]                  operation,
	input  logic [3:0]                  first_reg,
	input  logic [3:0]                  second_reg,
	input  logic [3:0]                  base_reg,
	input  logic signed [31:0]          immediate,
	input  logic [9:0]                  target_line,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mcec_pkg::PcW-1:0]    next_pc,
	output logic [mcec_pkg::TotW-1:0]   multi_cycles,
	output logic [mcec_pkg::CntW-1:0]   instruction_count,
	output logic                        halted,
	output logic                        divide_fault,
	output logic                        address_fault
);
	import mcec_pkg::*;

	mcec_cmd_t  cmd;
	mcec_stat_t stat;

	assign cfg_ready = 1'b1;

	mcec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	mcec_dp #(
		.DATA_WORDS    (DATA_WORDS),
		.PROGRAM_LINES (PROGRAM_LINES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_wr            (cfg_valid && cfg_ready),
		.cfg_data          (program_length),
		.operation         (operation),
		.first_reg         (first_reg),
		.second_reg        (second_reg),
		.base_reg          (base_reg),
		.immediate         (immediate),
		.target_line       (target_line),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.next_pc           (next_pc),
		.multi_cycles      (multi_cycles),
		.instruction_count (instruction_count),
		.halted            (halted),
		.divide_fault      (divide_fault),
		.address_fault     (address_fault)
	);
endmodule

@@ tb/mcec_checker.sv @@
// Checker for the instruction executor: predicts each result item and compares it.
module mcec_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [mcec_pkg::PcW-1:0]        program_length,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [3:0]                      operation,
	input  logic [3:0]                      first_reg,
	input  logic [3:0]                      second_reg,
	input  logic [3:0]                      base_reg,
	input  logic signed [31:0]              immediate,
	input  logic [9:0]                      target_line,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [mcec_pkg::PcW-1:0]        next_pc,
	input  logic [mcec_pkg::TotW-1:0]       multi_cycles,
	input  logic [mcec_pkg::CntW-1:0]       instruction_count,
	input  logic                            halted,
	input  logic                            divide_fault,
	input  logic                            address_fault,
	output int                              failures,
	output int                              pending,
	output int                              checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import mcec_pkg::*;

	localparam int MEM_WORDS = DataWordsDef;
	localparam int MEM_AW = $clog2(MEM_WORDS);
	localparam int LINE_CAP = ProgLinesDef;

	typedef struct packed {
		logic [PcW-1:0]  pc;
		logic [TotW-1:0] total;
		logic [CntW-1:0] count;
		logic            stop;
		logic            dfault;
		logic            afault;
	} outcome_t;

	logic [31:0]     regs [16];
	logic [31:0]     mem [MEM_WORDS];
	logic [PcW-1:0]  pc;
	logic [TotW-1:0] total;
	logic [CntW-1:0] count;
	logic            stop;
	logic [PcW-1:0]  plen;
	outcome_t        awaited [$];

	function automatic outcome_t execute(input logic [3:0] op, input logic [3:0] r1,
			input logic [3:0] r2, input logic [3:0] rb, input logic [31:0] imm,
			input logic [9:0] tgt);
		outcome_t o;
		logic [PcW-1:0] lim;
		logic [31:0] a, b, addr, res;
		logic [2:0] cost;
		logic [PcW-1:0] npc;
		logic [TotW:0] sum;
		logic wr, ok;
		o = '0;
		lim = (plen < LINE_CAP) ? plen : PcW'(LINE_CAP);
		if (stop || pc >= lim) begin
			stop = 1'b1;
		end else begin
			a = regs[r1];
			b = regs[r2];
			addr = imm + regs[rb];
			ok = !addr[31] && addr < MEM_WORDS;
			npc = pc + 1'b1;
			wr = 1'b0;
			res = '0;
			cost = COST_ALU;
			case (op)
				OP_ADD: begin
					res = a + b; wr = 1'b1;
				end
				OP_SUB: begin
					res = a - b; wr = 1'b1;
				end
				OP_DIV: begin
					wr = 1'b1;
					if (b == 0) begin
						o.dfault = 1'b1;
						res = '0;
					end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
						res = a;
					end else begin
						res = $signed(a) / $signed(b);
					end
				end
				OP_MULT: begin
					res = a * b; wr = 1'b1;
				end
				OP_SLT: begin
					res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; wr = 1'b1;
				end
				OP_LW: begin
					cost = COST_LW;
					if (ok) begin
						res = mem[addr[MEM_AW-1:0]]; wr = 1'b1;
					end else begin
						o.afault = 1'b1;
					end
				end
				OP_SW: begin
					if (ok) mem[addr[MEM_AW-1:0]] = a;
					else o.afault = 1'b1;
				end
				OP_BEQ: begin
					cost = COST_BR;
					if (a == b) npc = PcW'(tgt);
				end
				OP_ADDI: begin
					res = b + imm; wr = 1'b1;
				end
				OP_J: begin
					cost = COST_BR;
					npc = PcW'(tgt);
				end
				OP_SHOW: cost = COST_BR;
				default: begin
					cost = COST_NONE;
					npc = lim;
					stop = 1'b1;
				end
			endcase
			if (wr && r1 != 0) regs[r1] = res;
			sum = {1'b0, total} + (TotW + 1)'(cost);
			total = sum[TotW] ? '1 : sum[TotW-1:0];
			count = count + 1'b1;
			pc = npc;
			if (count > INSTR_LIMIT || pc >= lim) stop = 1'b1;
		end
		o.pc = pc;
		o.total = total;
		o.count = count;
		o.stop = stop;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got, want;
		if (!arst_n) begin
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			pc = '0;
			total = '0;
			count = '0;
			stop = 1'b0;
			plen = '0;
			awaited.delete();
			failures = 0;
			checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) plen = program_length;
			if (out_valid && !out_stall) begin
				got = '{next_pc, multi_cycles, instruction_count, halted, divide_fault,
					address_fault};
				if (awaited.size() == 0) begin
					failures++;
					if (failures <= 10) $display("Result item with no expectation: %p", got);
				end else begin
					want = awaited.pop_front();
					checked++;
					if (got !== want) begin
						failures++;
						if (failures <= 10)
							$display("Mismatch on result %0d: expected %p, got %p",
								checked, want, got);
					end
				end
			end
			if (in_valid && !in_stall)
				awaited = {awaited, execute(operation, first_reg, second_reg, base_reg,
					immediate, target_line)};
		end
		pending = awaited.size();
	end
endmodule

@@ tb/tb_mini_cpu_execute_cycle_counter.sv @@
// Top of the executor testbench: clock, reset, stimulus, receiver stalls and the verdict.
module tb_mini_cpu_execute_cycle_counter;
	timeunit 1ns;
	timeprecision 1ps;
	import mcec_pkg::*;

	localparam logic [3:0] OP_END = 4'd11;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [PcW-1:0]      program_length = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [3:0]          operation = '0;
	logic [3:0]          first_reg = '0;
	logic [3:0]          second_reg = '0;
	logic [3:0]          base_reg = '0;
	logic signed [31:0]  immediate = '0;
	logic [9:0]          target_line = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [PcW-1:0]      next_pc;
	logic [TotW-1:0]     multi_cycles;
	logic [CntW-1:0]     instruction_count;
	logic                halted;
	logic                divide_fault;
	logic                address_fault;
	int                  failures, pending, checked;
	int                  sent = 0;
	int                  since_jump = 0;
	logic                hold_off = 1'b0;

	mini_cpu_execute_cycle_counter dut (.*);
	mcec_checker checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		int mode, left;
		if (left <= 0) begin
			mode = $urandom_range(0, 3);
			left = $urandom_range(20, 200);
		end
		left--;
		case (mode)
			0: out_stall <= hold_off;
			1: out_stall <= hold_off || ($urandom_range(0, 9) < 3);
			2: out_stall <= hold_off || ($urandom_range(0, 9) < 7);
			default: out_stall <= hold_off || (left % 8 < 4);
		endcase
	end

	initial begin
		wait (sent >= 900);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send(input logic [3:0] op, input logic [3:0] r1, input logic [3:0] r2,
			input logic [3:0] rb, input logic [31:0] imm, input logic [9:0] tgt);
		in_valid <= 1'b1;
		operation <= op;
		first_reg <= r1;
		second_reg <= r2;
		base_reg <= rb;
		immediate <= imm;
		target_line <= tgt;
		do @(posedge clk); while (in_stall);
		sent++;
		since_jump = (op == OP_J) ? 0 : since_jump + 1;
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic set_length(input logic [PcW-1:0] v);
		idle_gap(1);
		wait (pending == 0);
		@(posedge clk);
		repeat (60) @(posedge clk);
		cfg_valid <= 1'b1;
		program_length <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random();
		logic [3:0] op, rb;
		logic [31:0] imm;
		int pick;
		op = 4'($urandom_range(0, 10));
		if (since_jump >= 15) op = OP_J;
		rb = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 9);
		if (pick < 4) imm = $urandom_range(0, 70);
		else if (pick < 7) imm = $urandom();
		else imm = 32'($signed($urandom_range(0, 16)) - 8);
		if ((op == OP_LW || op == OP_SW) && pick < 5) rb = '0;
		send(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), rb, imm,
			10'($urandom_range(0, 900)));
	endtask

	task automatic random_burst(input int n);
		int done_n, burst;
		done_n = 0;
		while (done_n < n) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && done_n < n; k++) begin
				send_random();
				done_n++;
			end
			idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_length(11'd1024);

		send(OP_ADDI, 4'd1, 4'd0, 4'd0, 32'h8000_0000, 10'd0);
		send(OP_ADDI, 4'd2, 4'd0, 4'd0, 32'hFFFF_FFFF, 10'd0);
		send(OP_ADDI, 4'd15, 4'd0, 4'd0, 32'h7FFF_FFFF, 10'd0);
		send(OP_ADDI, 4'd0, 4'd1, 4'd0, 32'd5, 10'd0);
		send(OP_DIV, 4'd3, 4'd1, 4'd0, 32'd0, 10'd0);
		send(OP_DIV, 4'd3, 4'd2, 4'd0, 32'd0, 10'd0);
		send(OP_DIV, 4'd4, 4'd1, 4'd2, 32'd0, 10'd0);
		send(OP_DIV, 4'd5, 4'd15, 4'd2, 32'd0, 10'd0);
		send(OP_MULT, 4'd6, 4'd15, 4'd15, 32'd0, 10'd0);
		send(OP_ADD, 4'd7, 4'd15, 4'd15, 32'd0, 10'd0);
		send(OP_SUB, 4'd8, 4'd1, 4'd15, 32'd0, 10'd0);
		send(OP_SLT, 4'd9, 4'd1, 4'd15, 32'd0, 10'd0);
		send(OP_SLT, 4'd10, 4'd15, 4'd1, 32'd0, 10'd0);
		send(OP_SW, 4'd15, 4'd0, 4'd0, 32'd62, 10'd0);
		send(OP_SW, 4'd0, 4'd0, 4'd0, 32'd63, 10'd0);
		send(OP_LW, 4'd11, 4'd0, 4'd0, 32'd62, 10'd0);
		send(OP_LW, 4'd12, 4'd0, 4'd0, 32'd63, 10'd0);
		send(OP_LW, 4'd13, 4'd0, 4'd2, 32'd0, 10'd0);
		send(OP_LW, 4'd13, 4'd0, 4'd0, 32'd64, 10'd0);
		send(OP_SW, 4'd15, 4'd0, 4'd0, 32'h8000_0000, 10'd0);
		send(OP_BEQ, 4'd1, 4'd1, 4'd0, 32'd0, 10'd1023);
		send(OP_J, 4'd0, 4'd0, 4'd0, 32'd0, 10'd5);
		send(OP_BEQ, 4'd1, 4'd15, 4'd0, 32'd0, 10'd7);
		send(OP_SHOW, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF, 10'd1023);

		random_burst(600);
		set_length(11'd2047);
		random_burst(600);
		set_length(11'd1000);
		random_burst(700);

		send(4'($urandom_range(11, 15)), 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom(),
			10'($urandom_range(0, 1023)));
		for (int k = 0; k < 6; k++)
			send(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom(),
				10'($urandom_range(0, 1023)));
		set_length(11'd0);
		for (int k = 0; k < 4; k++) send_random();
		idle_gap(1);

		wait (pending == 0);
		repeat (60) @(posedge clk);
		$display("Executed %0d instruction items, %0d results checked, over program lengths",
			sent, checked);
		$display("of 1024, 2047, 1000 and 0, ending with a halt and items after it.");
		if (failures == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
